@@ design/sfs_pkg.sv @@
// sfs_pkg: shared types and codes for the sprite frame sequencer
// no dependencies; used by every module of the block
package sfs_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_FRAME = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;
	localparam logic [1:0] CMD_START = 2'd3;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_COUNT = 2'd1;
	localparam logic [1:0] STAT_UNSET     = 2'd2;

	localparam int TIME_W      = 24;
	localparam int CQ_DEPTH    = 2;
	localparam int RQ_DEPTH    = 4;
	localparam int MAX_RESULTS = 16;

	typedef struct packed {
		logic [1:0]        op;
		logic [1:0]        err;
		logic [TIME_W-1:0] step;
		logic [3:0]        chan;
		logic [3:0]        def;
		logic [3:0]        slot;
		logic [TIME_W-1:0] dur;
		logic [7:0]        row;
		logic [7:0]        col;
		logic [7:0]        total;
		logic              loop;
		logic              flip;
	} cmd_t;

	typedef struct packed {
		logic [3:0] chan;
		logic [3:0] frame;
		logic [7:0] row;
		logic [7:0] col;
		logic       flip;
		logic [1:0] status;
		logic       last;
	} res_t;

endpackage

@@ design/sfs_front.sv @@
// sfs_front: accepts input beats, range-checks them and queues them for the back end
// depends on sfs_pkg
module sfs_front #(
	parameter int NUM_CHANNELS   = 16,
	parameter int NUM_DEFS       = 16,
	parameter int FRAMES_PER_DEF = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           cmd,
	input  logic [23:0]          time_step,
	input  logic [3:0]           channel_index,
	input  logic [3:0]           def_index,
	input  logic [3:0]           frame_slot,
	input  logic [23:0]          frame_duration,
	input  logic [7:0]           sprite_row,
	input  logic [7:0]           sprite_col,
	input  logic [7:0]           frame_total,
	input  logic                 loop_flag,
	input  logic                 flip_flag,
	output sfs_pkg::cmd_t        item,
	output logic                 item_valid,
	input  logic                 item_take
);

	localparam int AW = (sfs_pkg::CQ_DEPTH > 1) ? $clog2(sfs_pkg::CQ_DEPTH) : 1;
	localparam int CW = $clog2(sfs_pkg::CQ_DEPTH + 1);

	sfs_pkg::cmd_t  cls;
	sfs_pkg::cmd_t  q_q [sfs_pkg::CQ_DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           ch_bad, def_bad, slot_bad, tot_bad, do_push, do_pop;

	always_comb begin
		ch_bad   = 32'(channel_index) >= NUM_CHANNELS;
		def_bad  = 32'(def_index) >= NUM_DEFS;
		slot_bad = 32'(frame_slot) >= FRAMES_PER_DEF;
		tot_bad  = (frame_total == 8'd0) || (32'(frame_total) > FRAMES_PER_DEF);
		cls.op    = cmd;
		cls.step  = time_step;
		cls.chan  = channel_index;
		cls.def   = def_index;
		cls.slot  = frame_slot;
		cls.dur   = frame_duration;
		cls.row   = sprite_row;
		cls.col   = sprite_col;
		cls.total = frame_total;
		cls.loop  = loop_flag;
		cls.flip  = flip_flag;
		unique case (cmd)
			sfs_pkg::CMD_TICK: begin
				cls.err = sfs_pkg::STAT_OK;
			end
			sfs_pkg::CMD_FRAME: begin
				cls.err = def_bad ? sfs_pkg::STAT_UNSET :
					slot_bad ? sfs_pkg::STAT_BAD_COUNT : sfs_pkg::STAT_OK;
			end
			sfs_pkg::CMD_COUNT: begin
				cls.err = def_bad ? sfs_pkg::STAT_UNSET :
					tot_bad ? sfs_pkg::STAT_BAD_COUNT : sfs_pkg::STAT_OK;
			end
			sfs_pkg::CMD_START: begin
				cls.err = (ch_bad || def_bad) ? sfs_pkg::STAT_UNSET : sfs_pkg::STAT_OK;
				// unknown channel reports channel 0
				if (ch_bad) begin
					cls.chan = 4'd0;
				end
			end
			default: begin
				cls.err = sfs_pkg::STAT_OK;
			end
		endcase
	end

	assign full       = (cnt_q == CW'(sfs_pkg::CQ_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = q_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(sfs_pkg::CQ_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(sfs_pkg::CQ_DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ design/sfs_rfifo.sv @@
// sfs_rfifo: result queue between the back end and the result port
// depends on sfs_pkg
module sfs_rfifo (
	input  logic          clk,
	input  logic          arst_n,
	input  sfs_pkg::res_t in_res,
	input  logic          in_push,
	output logic          in_full,
	output sfs_pkg::res_t out_res,
	output logic          out_empty,
	input  logic          out_pop
);

	localparam int AW = (sfs_pkg::RQ_DEPTH > 1) ? $clog2(sfs_pkg::RQ_DEPTH) : 1;
	localparam int CW = $clog2(sfs_pkg::RQ_DEPTH + 1);

	sfs_pkg::res_t q_q [sfs_pkg::RQ_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign in_full   = (cnt_q == CW'(sfs_pkg::RQ_DEPTH));
	assign out_empty = (cnt_q == '0);
	assign out_res   = q_q[rp_q];
	assign do_push   = in_push && !in_full;
	assign do_pop    = out_pop && !out_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wp_q] <= in_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(sfs_pkg::RQ_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(sfs_pkg::RQ_DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ design/sfs_back.sv @@
// sfs_back: executes queued commands against the channel, count and frame memories
// depends on sfs_pkg; feeds sfs_rfifo
module sfs_back #(
	parameter int NUM_CHANNELS   = 16,
	parameter int NUM_DEFS       = 16,
	parameter int FRAMES_PER_DEF = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sfs_pkg::cmd_t item,
	input  logic          item_valid,
	output logic          item_take,
	output sfs_pkg::res_t res,
	output logic          res_push,
	input  logic          res_full
);

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int DF_W  = (NUM_DEFS > 1) ? $clog2(NUM_DEFS) : 1;
	localparam int FR_W  = $clog2(FRAMES_PER_DEF);
	localparam int CNT_W = $clog2(FRAMES_PER_DEF + 1);
	localparam int FA_N  = NUM_DEFS * FRAMES_PER_DEF;
	localparam int FA_W  = $clog2(FA_N);
	localparam int TW    = sfs_pkg::TIME_W;
	localparam int CM_W  = DF_W + 2 + TW + FR_W;
	localparam int FM_W  = TW + 16;
	localparam int N_W   = $clog2(sfs_pkg::MAX_RESULTS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWAIT = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_CH    = 3'd3;
	localparam logic [2:0] S_CNT   = 3'd4;
	localparam logic [2:0] S_FR    = 3'd5;
	localparam logic [2:0] S_PUSH  = 3'd6;
	localparam logic [2:0] S_NEXT  = 3'd7;

	function automatic logic [FA_W-1:0] faddr(logic [DF_W-1:0] d, logic [FR_W-1:0] f);
		return FA_W'(32'(d) * FRAMES_PER_DEF + 32'(f));
	endfunction

	logic [2:0]              state_q;
	sfs_pkg::cmd_t           cur_q;
	sfs_pkg::res_t           res_q;
	logic [CH_W-1:0]         idx_q;
	logic [N_W-1:0]          n_q;
	logic [NUM_CHANNELS-1:0] active_q;
	logic [NUM_DEFS-1:0]     dvalid_q;
	logic [DF_W-1:0]         w_def_q;
	logic [1:0]              w_mode_q;
	logic [FR_W-1:0]         w_frame_q;
	logic [TW-1:0]           w_time_q;
	logic                    w_exp_q;

	logic [CM_W-1:0]  cmem [NUM_CHANNELS];
	logic [CNT_W-1:0] kmem [NUM_DEFS];
	logic [FM_W-1:0]  fmem [FA_N];
	logic             cm_we, km_we, fm_we;
	logic [CM_W-1:0]  cm_wd, cm_rd;
	logic [CH_W-1:0]  cm_wa;
	logic [CNT_W-1:0] km_rd;
	logic [DF_W-1:0]  km_wa;
	logic [FA_W-1:0]  fm_wa, fm_ra;
	logic [FM_W-1:0]  fm_wd, fm_rd;

	logic [CH_W+3:0]  ch_ext;
	logic [DF_W+3:0]  def_ext;
	logic [FR_W+3:0]  slot_ext;
	logic [CH_W-1:0]  ch_sel;
	logic [DF_W-1:0]  def_sel;
	logic [FR_W-1:0]  slot_sel;
	logic [DF_W-1:0]  rd_def;
	logic [1:0]       rd_mode;
	logic [TW-1:0]    rd_time;
	logic [FR_W-1:0]  rd_frame;
	logic [CNT_W-1:0] cnt, cnt_m1;
	logic [FR_W:0]    nf_w;
	logic [FR_W-1:0]  nf_sel, new_frame, hold_frame;
	logic [TW-1:0]    new_time;
	logic [NUM_CHANNELS-1:0] above;
	logic             any_above, start_ok, last_ch;
	logic [CH_W+3:0]  idx_ext;
	logic [FR_W+3:0]  fr_ext;
	sfs_pkg::res_t    idle_res, start_res, tick_res;

	assign ch_ext   = {{CH_W{1'b0}}, item.chan};
	assign def_ext  = {{DF_W{1'b0}}, item.def};
	assign slot_ext = {{FR_W{1'b0}}, item.slot};
	assign ch_sel   = ch_ext[CH_W-1:0];
	assign def_sel  = def_ext[DF_W-1:0];
	assign slot_sel = slot_ext[FR_W-1:0];

	assign rd_frame = cm_rd[FR_W-1:0];
	assign rd_time  = cm_rd[FR_W+TW-1:FR_W];
	assign rd_mode  = cm_rd[FR_W+TW+1:FR_W+TW];
	assign rd_def   = cm_rd[CM_W-1:FR_W+TW+2];

	assign item_take = (state_q == S_IDLE) && item_valid;
	assign start_ok  = (item.err == sfs_pkg::STAT_OK) && dvalid_q[def_sel];
	assign res       = res_q;
	assign res_push  = (state_q == S_PUSH) && !res_full;

	// next frame after expiry, from the count seen now
	always_comb begin
		cnt        = dvalid_q[w_def_q] ? km_rd : '0;
		cnt_m1     = cnt - CNT_W'(1);
		hold_frame = (cnt == '0) ? '0 : FR_W'(cnt_m1);
		nf_w       = {1'b0, w_frame_q} + (FR_W+1)'(1);
		if (32'(nf_w) >= 32'(cnt)) begin
			nf_sel = w_mode_q[0] ? '0 : hold_frame;
		end else begin
			nf_sel = nf_w[FR_W-1:0];
		end
		new_frame = w_exp_q ? nf_sel : w_frame_q;
		new_time  = w_exp_q ? fm_rd[FM_W-1:16] : w_time_q;
		idx_ext   = {4'b0, idx_q};
		fr_ext    = {4'b0, w_frame_q};
	end

	always_comb begin
		for (int j = 0; j < NUM_CHANNELS; j++) begin
			above[j] = active_q[j] && (32'(idx_q) < j);
		end
		any_above = |above;
		last_ch   = (32'(n_q) == sfs_pkg::MAX_RESULTS - 1) || !any_above;
	end

	// result beats for a taken command, a finished start and a tick channel
	always_comb begin
		idle_res        = '0;
		idle_res.status = item.err;
		idle_res.last   = 1'b1;
		if (item.op == sfs_pkg::CMD_START) begin
			idle_res.chan = item.chan;
			if (!start_ok) begin
				idle_res.status = sfs_pkg::STAT_UNSET;
			end
		end
		start_res      = res_q;
		start_res.row  = fm_rd[15:8];
		start_res.col  = fm_rd[7:0];
		start_res.flip = cur_q.flip;
		tick_res.chan   = idx_ext[3:0];
		tick_res.frame  = fr_ext[3:0];
		tick_res.row    = fm_rd[15:8];
		tick_res.col    = fm_rd[7:0];
		tick_res.flip   = w_mode_q[1];
		tick_res.status = sfs_pkg::STAT_OK;
		tick_res.last   = last_ch;
	end

	always_comb begin
		cm_we = 1'b0;
		cm_wa = idx_q;
		cm_wd = {w_def_q, w_mode_q, new_time, w_frame_q};
		km_we = 1'b0;
		km_wa = def_sel;
		fm_we = 1'b0;
		fm_wa = faddr(def_sel, slot_sel);
		fm_wd = {item.dur, item.row, item.col};
		fm_ra = faddr(w_def_q, new_frame);
		if (item_take) begin
			unique case (item.op)
				sfs_pkg::CMD_FRAME: begin
					fm_we = (item.err == sfs_pkg::STAT_OK);
				end
				sfs_pkg::CMD_COUNT: begin
					km_we = (item.err == sfs_pkg::STAT_OK);
				end
				sfs_pkg::CMD_START: begin
					cm_we = start_ok;
					cm_wa = ch_sel;
					cm_wd = {def_sel, item.flip, item.loop, {TW{1'b0}}, {FR_W{1'b0}}};
					fm_ra = faddr(def_sel, '0);
				end
				default: begin
				end
			endcase
		end else if (state_q == S_FR) begin
			cm_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cmem[cm_wa] <= cm_wd;
		end
		cm_rd <= cmem[idx_q];
		if (km_we) begin
			kmem[km_wa] <= CNT_W'(item.total);
		end
		km_rd <= kmem[rd_def];
		if (fm_we) begin
			fmem[fm_wa] <= fm_wd;
		end
		fm_rd <= fmem[fm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			res_q     <= '0;
			idx_q     <= '0;
			n_q       <= '0;
			active_q  <= '0;
			dvalid_q  <= '0;
			w_def_q   <= '0;
			w_mode_q  <= '0;
			w_frame_q <= '0;
			w_time_q  <= '0;
			w_exp_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cur_q <= item;
						res_q <= idle_res;
						unique case (item.op)
							sfs_pkg::CMD_TICK: begin
								idx_q   <= '0;
								n_q     <= '0;
								state_q <= S_SCAN;
							end
							sfs_pkg::CMD_FRAME: begin
								state_q <= S_PUSH;
							end
							sfs_pkg::CMD_COUNT: begin
								if (item.err == sfs_pkg::STAT_OK) begin
									dvalid_q[def_sel] <= 1'b1;
								end
								state_q <= S_PUSH;
							end
							sfs_pkg::CMD_START: begin
								if (start_ok) begin
									active_q[ch_sel] <= 1'b1;
									state_q <= S_SWAIT;
								end else begin
									state_q <= S_PUSH;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SWAIT: begin
					res_q   <= start_res;
					state_q <= S_PUSH;
				end
				S_SCAN: begin
					state_q <= active_q[idx_q] ? S_CH : S_NEXT;
				end
				S_CH: begin
					w_def_q   <= rd_def;
					w_mode_q  <= rd_mode;
					w_frame_q <= rd_frame;
					w_exp_q   <= (rd_time <= cur_q.step);
					w_time_q  <= rd_time - cur_q.step;
					state_q   <= S_CNT;
				end
				S_CNT: begin
					w_frame_q <= new_frame;
					state_q   <= S_FR;
				end
				S_FR: begin
					if (32'(n_q) < sfs_pkg::MAX_RESULTS) begin
						res_q   <= tick_res;
						n_q     <= n_q + N_W'(1);
						state_q <= S_PUSH;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_PUSH: begin
					if (!res_full) begin
						state_q <= (cur_q.op == sfs_pkg::CMD_TICK) ? S_NEXT : S_IDLE;
					end
				end
				S_NEXT: begin
					if (idx_q == CH_W'(NUM_CHANNELS - 1)) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CH_W'(1);
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/sprite_frame_sequencer.sv @@
// sprite_frame_sequencer: top level of the sprite animation channel bank
// depends on sfs_pkg, sfs_front, sfs_back, sfs_rfifo
//
//   channel   handshake         beat moves when   payload
//   input     push / full       push && !full     cmd .. flip_flag
//   result    empty / pop       pop && !empty     out_channel .. last
//
// write, count and failed start commands pass through the idle and push states, a good start also through a wait state
// a tick scans every channel slot, each reported active channel adding the channel, count, frame and push states;
// the channel state memory is walked one channel at a time, each active channel
// making dependent reads of channel state, frame count and frame entry
// reset clears channel activity and definition valid bits at once; no clearing pass
// input stalls only when the two-deep command queue is full, results wait in a
// four-deep queue and the back end holds while it is full
module sprite_frame_sequencer #(
	parameter int NUM_CHANNELS   = 16,
	parameter int NUM_DEFS       = 16,
	parameter int FRAMES_PER_DEF = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [23:0] time_step,
	input  logic [3:0]  channel_index,
	input  logic [3:0]  def_index,
	input  logic [3:0]  frame_slot,
	input  logic [23:0] frame_duration,
	input  logic [7:0]  sprite_row,
	input  logic [7:0]  sprite_col,
	input  logic [7:0]  frame_total,
	input  logic        loop_flag,
	input  logic        flip_flag,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  out_channel,
	output logic [3:0]  frame_number,
	output logic [7:0]  out_row,
	output logic [7:0]  out_col,
	output logic        out_flip,
	output logic [1:0]  status,
	output logic        last
);

	sfs_pkg::cmd_t item;
	sfs_pkg::res_t bres, ores;
	logic          item_valid, item_take, res_push, res_full;

	sfs_front #(
		.NUM_CHANNELS   (NUM_CHANNELS),
		.NUM_DEFS       (NUM_DEFS),
		.FRAMES_PER_DEF (FRAMES_PER_DEF)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.cmd            (cmd),
		.time_step      (time_step),
		.channel_index  (channel_index),
		.def_index      (def_index),
		.frame_slot     (frame_slot),
		.frame_duration (frame_duration),
		.sprite_row     (sprite_row),
		.sprite_col     (sprite_col),
		.frame_total    (frame_total),
		.loop_flag      (loop_flag),
		.flip_flag      (flip_flag),
		.item           (item),
		.item_valid     (item_valid),
		.item_take      (item_take)
	);

	sfs_back #(
		.NUM_CHANNELS   (NUM_CHANNELS),
		.NUM_DEFS       (NUM_DEFS),
		.FRAMES_PER_DEF (FRAMES_PER_DEF)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.res        (bres),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	sfs_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_res    (bres),
		.in_push   (res_push),
		.in_full   (res_full),
		.out_res   (ores),
		.out_empty (empty),
		.out_pop   (pop)
	);

	assign out_channel  = ores.chan;
	assign frame_number = ores.frame;
	assign out_row      = ores.row;
	assign out_col      = ores.col;
	assign out_flip     = ores.flip;
	assign status       = ores.status;
	assign last         = ores.last;

endmodule

@@ sim/testbench.sv @@
// testbench for sprite_frame_sequencer: directed and random command streams with
// random idling on both queue sides, results checked against an in-bench channel model
// depends on sfs_pkg and the sprite_frame_sequencer rtl
module testbench;

	localparam int RX_STALL    = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_BEATS = 290;

	typedef enum logic [1:0] {PLAN_BEAT, PLAN_DRAIN, PLAN_STALL_RX} plan_t;

	typedef struct packed {
		plan_t       kind;
		logic [1:0]  cmd;
		logic [23:0] tstep;
		logic [3:0]  ch;
		logic [3:0]  def;
		logic [3:0]  slot;
		logic [23:0] dur;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [7:0]  total;
		logic        loop;
		logic        flip;
	} beat_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  cmd = sfs_pkg::CMD_TICK;
	logic [23:0] time_step = '0;
	logic [3:0]  channel_index = '0;
	logic [3:0]  def_index = '0;
	logic [3:0]  frame_slot = '0;
	logic [23:0] frame_duration = '0;
	logic [7:0]  sprite_row = '0;
	logic [7:0]  sprite_col = '0;
	logic [7:0]  frame_total = '0;
	logic        loop_flag = 1'b0;
	logic        flip_flag = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  out_channel;
	logic [3:0]  frame_number;
	logic [7:0]  out_row;
	logic [7:0]  out_col;
	logic        out_flip;
	logic [1:0]  status;
	logic        last;

	sprite_frame_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.cmd(cmd), .time_step(time_step), .channel_index(channel_index),
		.def_index(def_index), .frame_slot(frame_slot), .frame_duration(frame_duration),
		.sprite_row(sprite_row), .sprite_col(sprite_col), .frame_total(frame_total),
		.loop_flag(loop_flag), .flip_flag(flip_flag),
		.empty(empty), .pop(pop),
		.out_channel(out_channel), .frame_number(frame_number), .out_row(out_row),
		.out_col(out_col), .out_flip(out_flip), .status(status), .last(last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// channel model state
	logic [23:0]        entry_time [16][16];
	logic [7:0]         entry_row [16][16];
	logic [7:0]         entry_col [16][16];
	logic [4:0]         def_count [16];
	bit                 def_ready [16];
	bit                 ch_live [16];
	logic [3:0]         ch_def [16];
	logic               ch_wrap [16];
	logic               ch_mirror [16];
	logic signed [24:0] ch_left [16];
	logic [3:0]         ch_frame [16];

	// generator shadow of written entries and valid definitions
	bit gen_written [16][16];
	bit gen_ready [16];

	beat_t         plan_q [$];
	sfs_pkg::res_t pending_frames [$];
	beat_t         cur;

	int beats_offered = 0;
	int beats_taken = 0;
	int frames_seen = 0;
	int frames_paced = 0;
	int stalls_asked = 0;
	int stalls_served = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_gap = 0;
	int rx_calm = 0;
	int rx_hold = 0;

	function automatic int pick_gap(inout int calm);
		int roll;
		roll = $urandom_range(99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 3) begin
			calm = $urandom_range(60, 20);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [23:0] pick_duration();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 24'd0;
		if (roll < 14)
			return 24'hFFFFFF;
		if (roll < 24)
			return 24'($urandom);
		return 24'($urandom_range(24'h2000, 1));
	endfunction

	function automatic logic [23:0] pick_step();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			return 24'd0;
		if (roll < 28)
			return 24'hFFFFFF;
		if (roll < 38)
			return 24'($urandom);
		return 24'($urandom_range(24'h1800, 1));
	endfunction

	function automatic string show(input sfs_pkg::res_t r);
		return $sformatf("ch %0d frame %0d row %02h col %02h flip %0b status %0d last %0b",
			r.chan, r.frame, r.row, r.col, r.flip, r.status, r.last);
	endfunction

	function automatic int written_run(input int d);
		int s;
		s = 0;
		while (s < 16 && gen_written[d][s])
			s++;
		return s;
	endfunction

	function automatic beat_t scrambled_beat();
		beat_t b;
		b.kind  = PLAN_BEAT;
		b.cmd   = 2'($urandom);
		b.tstep = 24'($urandom);
		b.ch    = 4'($urandom);
		b.def   = 4'($urandom);
		b.slot  = 4'($urandom);
		b.dur   = 24'($urandom);
		b.row   = 8'($urandom);
		b.col   = 8'($urandom);
		b.total = 8'($urandom);
		b.loop  = 1'($urandom);
		b.flip  = 1'($urandom);
		return b;
	endfunction

	task automatic enqueue(input beat_t b);
		if (b.cmd == sfs_pkg::CMD_FRAME)
			gen_written[b.def][b.slot] = 1'b1;
		if (b.cmd == sfs_pkg::CMD_COUNT && b.total != 8'd0 && b.total <= 8'd16)
			gen_ready[b.def] = 1'b1;
		plan_q.push_back(b);
	endtask

	task automatic send_entry(input logic [3:0] d, input logic [3:0] s,
			input logic [23:0] dur, input logic [7:0] row, input logic [7:0] col);
		beat_t b;
		b = scrambled_beat();
		b.cmd  = sfs_pkg::CMD_FRAME;
		b.def  = d;
		b.slot = s;
		b.dur  = dur;
		b.row  = row;
		b.col  = col;
		enqueue(b);
	endtask

	task automatic send_count(input logic [3:0] d, input logic [7:0] t);
		beat_t b;
		b = scrambled_beat();
		b.cmd   = sfs_pkg::CMD_COUNT;
		b.def   = d;
		b.total = t;
		enqueue(b);
	endtask

	task automatic send_start(input logic [3:0] ch, input logic [3:0] d,
			input logic loop, input logic flip);
		beat_t b;
		b = scrambled_beat();
		b.cmd  = sfs_pkg::CMD_START;
		b.ch   = ch;
		b.def  = d;
		b.loop = loop;
		b.flip = flip;
		enqueue(b);
	endtask

	task automatic send_tick(input logic [23:0] step);
		beat_t b;
		b = scrambled_beat();
		b.cmd   = sfs_pkg::CMD_TICK;
		b.tstep = step;
		enqueue(b);
	endtask

	task automatic send_marker(input plan_t k);
		beat_t b;
		b = scrambled_beat();
		b.kind = k;
		plan_q.push_back(b);
	endtask

	task automatic advance_animation(input beat_t b);
		int                 i;
		int                 n;
		logic [3:0]         d;
		logic [4:0]         nf;
		logic signed [24:0] left;
		sfs_pkg::res_t      r;
		sfs_pkg::res_t      tick_out [16];
		r = '0;
		r.last = 1'b1;
		case (b.cmd)
			sfs_pkg::CMD_TICK: begin
				n = 0;
				for (i = 0; i < 16; i++) begin
					if (ch_live[i]) begin
						d = ch_def[i];
						left = ch_left[i] - $signed({1'b0, b.tstep});
						if (left <= 0) begin
							nf = {1'b0, ch_frame[i]} + 5'd1;
							if (nf >= def_count[d])
								nf = ch_wrap[i] ? 5'd0 : def_count[d] - 5'd1;
							ch_frame[i] = nf[3:0];
							left = $signed({1'b0, entry_time[d][nf[3:0]]});
						end
						ch_left[i] = left;
						tick_out[n].chan   = i[3:0];
						tick_out[n].frame  = ch_frame[i];
						tick_out[n].row    = entry_row[d][ch_frame[i]];
						tick_out[n].col    = entry_col[d][ch_frame[i]];
						tick_out[n].flip   = ch_mirror[i];
						tick_out[n].status = sfs_pkg::STAT_OK;
						tick_out[n].last   = 1'b0;
						n++;
					end
				end
				for (i = 0; i < n; i++) begin
					r = tick_out[i];
					r.last = (i == n - 1);
					pending_frames.push_back(r);
				end
			end
			sfs_pkg::CMD_FRAME: begin
				entry_time[b.def][b.slot] = b.dur;
				entry_row[b.def][b.slot]  = b.row;
				entry_col[b.def][b.slot]  = b.col;
				r.status = sfs_pkg::STAT_OK;
				pending_frames.push_back(r);
			end
			sfs_pkg::CMD_COUNT: begin
				if (b.total == 8'd0 || b.total > 8'd16) begin
					r.status = sfs_pkg::STAT_BAD_COUNT;
				end else begin
					def_count[b.def] = b.total[4:0];
					def_ready[b.def] = 1'b1;
					r.status = sfs_pkg::STAT_OK;
				end
				pending_frames.push_back(r);
			end
			sfs_pkg::CMD_START: begin
				r.chan = b.ch;
				if (!def_ready[b.def]) begin
					r.status = sfs_pkg::STAT_UNSET;
				end else begin
					ch_live[b.ch]   = 1'b1;
					ch_def[b.ch]    = b.def;
					ch_wrap[b.ch]   = b.loop;
					ch_mirror[b.ch] = b.flip;
					ch_left[b.ch]   = '0;
					ch_frame[b.ch]  = 4'd0;
					r.row    = entry_row[b.def][0];
					r.col    = entry_col[b.def][0];
					r.flip   = b.flip;
					r.status = sfs_pkg::STAT_OK;
				end
				pending_frames.push_back(r);
			end
			default: ;
		endcase
	endtask

	// sender: offer at the falling edge, take at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && push && !full) begin
			advance_animation(cur);
			beats_taken++;
		end
	end

	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			push <= 1'b0;
		end else if (beats_offered == beats_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else if (plan_q.size() == 0) begin
				push <= 1'b0;
			end else if (plan_q[0].kind == PLAN_DRAIN) begin
				push <= 1'b0;
				if (pending_frames.size() == 0)
					void'(plan_q.pop_front());
			end else if (plan_q[0].kind == PLAN_STALL_RX) begin
				push <= 1'b0;
				stalls_asked++;
				void'(plan_q.pop_front());
			end else begin
				cur = plan_q.pop_front();
				cmd            <= cur.cmd;
				time_step      <= cur.tstep;
				channel_index  <= cur.ch;
				def_index      <= cur.def;
				frame_slot     <= cur.slot;
				frame_duration <= cur.dur;
				sprite_row     <= cur.row;
				sprite_col     <= cur.col;
				frame_total    <= cur.total;
				loop_flag      <= cur.loop;
				flip_flag      <= cur.flip;
				push <= 1'b1;
				beats_offered++;
				tx_gap = pick_gap(tx_calm);
			end
		end
	end

	// receiver side
	always @(posedge clk) begin
		sfs_pkg::res_t got;
		sfs_pkg::res_t want;
		if (arst_n === 1'b1 && pop && !empty) begin
			got = '{chan: out_channel, frame: frame_number, row: out_row, col: out_col,
				flip: out_flip, status: status, last: last};
			frames_seen++;
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %s", show(got));
			end else begin
				want = pending_frames.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %s, got %s", show(want), show(got));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			pop <= 1'b0;
		end else begin
			if (frames_paced != frames_seen) begin
				frames_paced = frames_seen;
				rx_gap = pick_gap(rx_calm);
			end
			if (stalls_served != stalls_asked) begin
				stalls_served = stalls_asked;
				rx_hold = RX_STALL;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int k;
		int d;
		int t;
		int run;
		int roll;
		logic [3:0] s;

		// no channel active yet
		send_tick(24'd0);
		send_start(4'd5, 4'd3, 1'b1, 1'b1);
		send_count(4'd0, 8'd0);
		send_count(4'd0, 8'd17);
		send_count(4'd15, 8'd255);
		send_entry(4'd0, 4'd0, 24'd0, 8'h00, 8'h00);
		send_entry(4'd0, 4'd1, 24'hFFFFFF, 8'hFF, 8'hFF);
		send_entry(4'd0, 4'd2, 24'd1, 8'hAA, 8'h55);
		send_count(4'd0, 8'd3);
		send_start(4'd0, 4'd0, 1'b1, 1'b1);
		send_start(4'd15, 4'd0, 1'b0, 1'b0);
		// zero step still advances a fresh channel, then wrap vs hold
		send_tick(24'd0);
		send_tick(24'hFFFFFF);
		send_tick(24'd1);
		send_tick(24'd0);
		// restart a running channel, then shrink the count under it
		send_start(4'd0, 4'd0, 1'b0, 1'b1);
		send_count(4'd0, 8'd1);
		send_tick(24'hFFFFFF);
		send_entry(4'd15, 4'd15, 24'hFFFFFF, 8'hFF, 8'h00);
		send_marker(PLAN_DRAIN);

		for (k = 0; k < RANDOM_BEATS; k++) begin
			if (k == 70 || k == 220)
				send_marker(PLAN_STALL_RX);
			if (k == 150)
				send_marker(PLAN_DRAIN);
			roll = $urandom_range(99);
			if (roll < 28) begin
				d = $urandom_range(15);
				run = written_run(d);
				if (run < 16 && $urandom_range(99) < 70)
					s = 4'(run);
				else
					s = 4'($urandom_range(15));
				send_entry(4'(d), s, pick_duration(), 8'($urandom), 8'($urandom));
			end else if (roll < 43) begin
				d = $urandom_range(15);
				run = written_run(d);
				if (run > 0 && $urandom_range(99) < 75)
					send_count(4'(d), 8'($urandom_range(run, 1)));
				else if ($urandom_range(1) == 0)
					send_count(4'(d), 8'd0);
				else
					send_count(4'(d), 8'($urandom_range(255, 17)));
			end else if (roll < 62) begin
				d = $urandom_range(15);
				if ($urandom_range(99) < 80)
					for (t = 0; t < 16 && !gen_ready[d]; t++)
						d = (d + 1) % 16;
				send_start(4'($urandom_range(15)), 4'(d), 1'($urandom), 1'($urandom));
			end else begin
				send_tick(pick_step());
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (plan_q.size() != 0 || beats_offered != beats_taken)
			@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
